// File: rtl/rhg_pkg.sv
// Shared types, constants and gamma table of the RGB to HSV gamma unit.
package rhg_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned DivSteps   = 16;

  localparam logic [15:0] SectorSpan = 16'h2AAA;
  localparam logic [15:0] GreenBase  = 16'h5555;
  localparam logic [15:0] BlueBase   = 16'hAAAA;
  localparam logic [15:0] RedBase    = 16'h0000;
  localparam logic [15:0] Full16     = 16'hFFFF;
  localparam int unsigned ByteSpread = 257;
  localparam int unsigned KnotStep   = 4;

  typedef logic [15:0] gamma_rom_t [256];

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [15:0] v;
    logic [15:0] d;
    logic [15:0] mag;
    logic        neg;
    logic [15:0] base;
    logic        gray;
  } class_t;

  typedef struct packed {
    logic [31:0] snum;
    logic [29:0] hnum;
    logic [15:0] v;
    logic [15:0] d;
    logic [15:0] base;
    logic        neg;
    logic        gray;
  } item_t;

  typedef struct packed {
    logic [15:0] srem;
    logic [15:0] squo;
    logic [15:0] hrem;
    logic [15:0] hquo;
    logic [15:0] v;
    logic [15:0] d;
    logic [15:0] base;
    logic        neg;
    logic        gray;
  } div_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
  } hsv_t;

  function automatic logic [15:0] knot_value(input logic [63:0] x);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] odd;
    target = 64'd4 * x * x * x;
    lo = 64'd0;
    hi = 64'd65600;
    for (int i = 0; i < 20; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        odd = (mid << 1) - 64'd1;
        if (odd * odd * 64'd65535 <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return (lo > 64'd65535) ? Full16 : lo[15:0];
  endfunction

  function automatic gamma_rom_t build_gamma_rom();
    gamma_rom_t  rom;
    logic [63:0] pos;
    logic [63:0] base;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] e;
    for (int c = 0; c < 256; c++) begin
      pos  = 64'(c) * 64'(ByteSpread);
      t    = pos % 64'(KnotStep);
      base = pos - t;
      a    = 64'(knot_value(base));
      b    = 64'(knot_value(base + 64'(KnotStep)));
      e    = a + ((b - a) * t) / 64'(KnotStep);
      rom[c] = e[15:0];
    end
    return rom;
  endfunction

  localparam gamma_rom_t GammaRom = build_gamma_rom();

endpackage

// File: rtl/rhg_if.sv
// Pixel and HSV channel interfaces with valid/ready handshake.
interface rhg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhg_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [15:0] saturation;
  logic [15:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// File: rtl/rgb8_to_hsv16_gamma_unit.sv
// Top level of the 8-bit RGB to 16-bit HSV converter with gamma expansion.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// 16-stage restoring divider pipeline.
// The front end stalls only when the item queue is full; the back end stalls on output.
// Reset is asynchronous, active low, and clears all valid bits and queue pointers.
module rgb8_to_hsv16_gamma_unit import rhg_pkg::*; #(
  parameter int unsigned QueueDepth = rhg_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhg_pix_if.sink   in_i,
  rhg_hsv_if.source out_o
);

  queue_stat_t q_stat;
  logic        q_push;
  logic        q_pop;
  item_t       q_in;
  item_t       q_out;

  rhg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (in_i),
    .stat_i (q_stat),
    .push_o (q_push),
    .item_o (q_in)
  );

  rhg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  rhg_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (q_stat),
    .item_i (q_out),
    .pop_o  (q_pop),
    .hsv_o  (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.brightness == 16'h0000) |->
      (out_o.saturation == 16'h0000 && out_o.hue == 16'h0000))
    else $error("black pixel with nonzero hue or saturation");

endmodule

// File: rtl/rhg_front.sv
// Front end: gamma lookup, sector classification and numerator products.
module rhg_front import rhg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhg_pix_if.sink     pix_i,
  input  queue_stat_t stat_i,
  output logic        push_o,
  output item_t       item_o
);

  logic        adv;
  logic        a_valid_q;
  logic [15:0] gr_q, gg_q, gb_q;
  logic        b_valid_q;
  class_t      cls_d, cls_q;
  logic [15:0] v, l;
  logic [16:0] diff;

  assign adv         = !stat_i.full;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= pix_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gr_q  <= GammaRom[pix_i.red];
      gg_q  <= GammaRom[pix_i.green];
      gb_q  <= GammaRom[pix_i.blue];
      cls_q <= cls_d;
    end
  end

  always_comb begin
    v = gr_q;
    l = gr_q;
    if (gg_q > v) v = gg_q;
    if (gb_q > v) v = gb_q;
    if (gg_q < l) l = gg_q;
    if (gb_q < l) l = gb_q;
    if (gg_q == v) begin
      diff = {1'b0, gb_q} - {1'b0, gr_q};
      cls_d.base = GreenBase;
    end else if (gb_q == v) begin
      diff = {1'b0, gr_q} - {1'b0, gg_q};
      cls_d.base = BlueBase;
    end else begin
      diff = {1'b0, gg_q} - {1'b0, gb_q};
      cls_d.base = RedBase;
    end
    cls_d.v    = v;
    cls_d.d    = v - l;
    cls_d.gray = (v == l);
    cls_d.neg  = diff[16];
    cls_d.mag  = diff[16] ? 16'(-diff) : diff[15:0];
  end

  assign push_o      = b_valid_q && adv;
  assign item_o.snum = {cls_q.d, 16'h0000} - {16'h0000, cls_q.d};
  assign item_o.hnum = 30'(cls_q.mag) * 30'(SectorSpan);
  assign item_o.v    = cls_q.v;
  assign item_o.d    = cls_q.d;
  assign item_o.base = cls_q.base;
  assign item_o.neg  = cls_q.neg;
  assign item_o.gray = cls_q.gray;

endmodule

// File: rtl/rhg_queue.sv
// Short item queue between the front end and the divider back end.
module rhg_queue import rhg_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       item_i,
  input  logic        pop_i,
  output item_t       item_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/rhg_back.sv
// Back end: pipelined saturation and hue dividers with output register.
module rhg_back import rhg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_stat_t stat_i,
  input  item_t       item_i,
  output logic        pop_o,
  rhg_hsv_if.source   hsv_o
);

  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [16:0] ts;
    logic [16:0] th;
    logic        gs;
    logic        gh;
    r  = s;
    ts = {s.srem, s.squo[15]};
    th = {s.hrem, s.hquo[15]};
    gs = (ts >= {1'b0, s.v});
    gh = (th >= {1'b0, s.d});
    r.srem = gs ? 16'(ts - {1'b0, s.v}) : ts[15:0];
    r.hrem = gh ? 16'(th - {1'b0, s.d}) : th[15:0];
    r.squo = {s.squo[14:0], gs};
    r.hquo = {s.hquo[14:0], gh};
    return r;
  endfunction

  logic              adv;
  logic [DivSteps:0] st_valid_q;
  div_t              st_q [DivSteps+1];
  div_t              st0_d;
  logic [31:0]       hnum;
  logic              out_valid_q;
  hsv_t              out_d, out_q;
  div_t              last;

  assign adv   = !out_valid_q || hsv_o.ready;
  assign pop_o = adv && !stat_i.empty;
  assign hnum  = {2'b00, item_i.hnum};

  always_comb begin
    st0_d.srem = item_i.snum[31:16];
    st0_d.squo = item_i.snum[15:0];
    st0_d.hrem = hnum[31:16];
    st0_d.hquo = hnum[15:0];
    st0_d.v    = item_i.v;
    st0_d.d    = item_i.d;
    st0_d.base = item_i.base;
    st0_d.neg  = item_i.neg;
    st0_d.gray = item_i.gray;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      st_valid_q  <= {st_valid_q[DivSteps-1:0], !stat_i.empty};
      out_valid_q <= st_valid_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= st0_d;
      out_q   <= out_d;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k+1] <= div_step(st_q[k]);
      end
    end
  end

  always_comb begin
    last = st_q[DivSteps];
    out_d.brightness = last.v;
    out_d.saturation = (last.v == '0) ? '0 : last.squo;
    if (last.gray) begin
      out_d.hue = '0;
    end else if (last.neg) begin
      out_d.hue = last.base - last.hquo;
    end else begin
      out_d.hue = last.base + last.hquo;
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = out_q.hue;
  assign hsv_o.saturation = out_q.saturation;
  assign hsv_o.brightness = out_q.brightness;

endmodule
